>>> rtl/eous_pkg.sv
// Shared types, constants and codes of the engine usage statistics block.
package eous_pkg;

  // Default counter width and queue depth.
  localparam int unsigned CountBits  = 32;
  localparam int unsigned QueueDepth = 4;

  localparam int unsigned RpmW   = 14;
  localparam int unsigned SpeedW = 8;
  localparam int unsigned SecW   = 29;

  // OBD-II reply matching.
  localparam logic [28:0] ReplyId  = 29'h7E8;
  localparam logic [7:0]  SvcReply = 8'h41;
  localparam logic [7:0]  PidRpm   = 8'h0C;
  localparam logic [7:0]  PidSpeed = 8'h0D;
  localparam logic [7:0]  LenRpm   = 8'h04;
  localparam logic [7:0]  LenSpeed = 8'h03;

  // Samples are taken ten per second.
  localparam logic [3:0] SecDivisor = 4'd10;

  // Register indexes and reset values.
  localparam logic          RegIdleRpm     = 1'b0;
  localparam logic          RegIdleSpeed   = 1'b1;
  localparam logic [13:0]   IdleRpmReset   = 14'd1600;
  localparam logic [8:0]    IdleSpeedReset = 9'd10;

  typedef enum logic [1:0] {
    MODE_FRAME  = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_REPORT = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic        is_extended;
    logic [28:0] frame_id;
    logic [7:0]  data_byte0;
    logic [7:0]  data_byte1;
    logic [7:0]  data_byte2;
    logic [7:0]  data_byte3;
    logic [7:0]  data_byte4;
  } in_word_t;

  typedef struct packed {
    logic [28:0] off_seconds;
    logic [28:0] idle_seconds;
    logic [28:0] busy_seconds;
    logic [13:0] rpm_min;
    logic [13:0] rpm_mean;
    logic [13:0] rpm_max;
    logic [7:0]  speed_min;
    logic [7:0]  speed_mean;
    logic [7:0]  speed_max;
  } out_word_t;

  // Commands passed from the front end to the statistics engine.
  typedef enum logic [1:0] {
    CMD_RPM    = 2'd0,
    CMD_SPEED  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        op;
    logic [13:0] value;
  } cmd_t;

  typedef struct packed {
    logic [13:0] idle_rpm_limit;
    logic [8:0]  idle_speed_limit;
  } cfg_t;

  typedef enum logic {
    ST_RUN = 1'b0,
    ST_DIV = 1'b1
  } state_e;

endpackage

>>> rtl/eous_front.sv
// Front end: accepts input words, decodes OBD-II replies and issues commands.
module eous_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  eous_pkg::in_word_t in_word_i,
  input  logic               push,
  output logic               full,
  output eous_pkg::cmd_t     cmd_o,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i
);
  import eous_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic keep;
  logic reply;
  logic take;

  assign full = valid_q && !cmd_ready_i;
  assign take = push && !full;

  always_comb begin
    reply = !in_word_i.is_extended && (in_word_i.frame_id == ReplyId) &&
            (in_word_i.data_byte1 == SvcReply);
    cmd_d.op    = CMD_TICK;
    cmd_d.value = '0;
    keep        = 1'b0;
    case (in_word_i.mode)
      MODE_FRAME: begin
        if (reply && in_word_i.data_byte0 == LenRpm && in_word_i.data_byte2 == PidRpm) begin
          cmd_d.op    = CMD_RPM;
          cmd_d.value = {in_word_i.data_byte3, in_word_i.data_byte4[7:2]};
          keep        = 1'b1;
        end else if (reply && in_word_i.data_byte0 == LenSpeed &&
                     in_word_i.data_byte2 == PidSpeed) begin
          cmd_d.op    = CMD_SPEED;
          cmd_d.value = {6'd0, in_word_i.data_byte3};
          keep        = 1'b1;
        end
      end
      MODE_TICK: begin
        cmd_d.op = CMD_TICK;
        keep     = 1'b1;
      end
      MODE_REPORT: begin
        cmd_d.op = CMD_REPORT;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (valid_q && cmd_ready_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d = keep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_o       = cmd_q;
  assign cmd_valid_o = valid_q;

endmodule

>>> rtl/eous_queue.sv
// Short command queue between the front end and the statistics engine.
module eous_queue #(
  parameter int unsigned DEPTH = eous_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  eous_pkg::cmd_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output eous_pkg::cmd_t rd_data_o
);
  import eous_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            entry_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_wr, do_rd;

  assign wr_ready_o = (count_q != CntW'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;
  assign rd_data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

>>> rtl/eous_div.sv
// Restoring serial divider, one quotient bit per cycle.
module eous_div #(
  parameter int unsigned NUM_W = 46,
  parameter int unsigned DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NUM_W + 1);

  logic [CntW-1:0]  cnt_q;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial, diff;

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    if (trial >= {1'b0, den_q}) begin
      rem_d = diff[DEN_W-1:0];
      num_d = {num_q[NUM_W-2:0], 1'b1};
    end else begin
      rem_d = trial[DEN_W-1:0];
      num_d = {num_q[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(NUM_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = num_q;

endmodule

>>> rtl/eous_back.sv
// Statistics engine: latches samples, keeps counts and builds reports.
module eous_back #(
  parameter int unsigned COUNT_BITS = eous_pkg::CountBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  eous_pkg::cfg_t      cfg_i,
  input  logic                cmd_valid_i,
  input  eous_pkg::cmd_t      cmd_i,
  output logic                cmd_ready_o,
  output eous_pkg::out_word_t out_word_o,
  output logic                empty,
  input  logic                pop
);
  import eous_pkg::*;

  localparam int unsigned RsumW = COUNT_BITS + RpmW;
  localparam int unsigned SsumW = COUNT_BITS + SpeedW;
  localparam int unsigned SecExtW = COUNT_BITS + SecW;
  localparam logic [SecW-1:0]   SecMax   = '1;
  localparam logic [RpmW-1:0]   RpmMax   = '1;
  localparam logic [SpeedW-1:0] SpeedMax = '1;
  localparam logic [3:0]        SecLast  = SecDivisor - 4'd1;

  state_e state_q, state_d;

  logic [RpmW-1:0]       latched_rpm_q;
  logic [SpeedW-1:0]     latched_speed_q;
  logic [COUNT_BITS-1:0] rpm_off_count_q, rpm_idle_count_q, rpm_busy_count_q;
  logic [COUNT_BITS-1:0] speed_busy_count_q;
  logic [RsumW-1:0]      rpm_busy_sum_q;
  logic [SsumW-1:0]      speed_busy_sum_q;
  logic [RpmW-1:0]       rpm_busy_min_q, rpm_busy_max_q;
  logic [SpeedW-1:0]     speed_busy_min_q, speed_busy_max_q;

  // Each engine count is also kept as whole seconds plus a tenths digit, so
  // the seconds never need a division. Both stop together when the count
  // saturates, which keeps the seconds equal to the count divided by ten.
  logic [3:0]            off_tenths_q, idle_tenths_q, busy_tenths_q;
  logic [COUNT_BITS-1:0] off_secs_q, idle_secs_q, busy_secs_q;

  logic      out_valid_q;
  out_word_t out_q, out_d;

  logic accept, div_start, finish, div_busy;
  logic rpm_off, rpm_idle, speed_busy;
  logic [RsumW:0] rsum_add;
  logic [SsumW:0] ssum_add;
  logic [RsumW-1:0] rsum_next;
  logic [SsumW-1:0] ssum_next;

  logic [RsumW-1:0]      rmean_quo;
  logic [SsumW-1:0]      smean_quo;
  logic                  rmean_busy, smean_busy;
  logic [SecExtW-1:0]    off_ext, idle_ext, busy_ext;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (accept && cmd_i.op == CMD_REPORT) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_d = ST_RUN;
        end
      end
    endcase
  end

  // Control outputs. A report waits until the result register is free.
  always_comb begin
    cmd_ready_o = 1'b0;
    div_start   = 1'b0;
    finish      = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        cmd_ready_o = !(cmd_i.op == CMD_REPORT && out_valid_q);
        div_start   = cmd_valid_i && cmd_ready_o && cmd_i.op == CMD_REPORT;
      end
      ST_DIV: begin
        finish = !div_busy;
      end
    endcase
  end

  assign accept   = cmd_valid_i && cmd_ready_o;
  assign div_busy = rmean_busy || smean_busy;

  always_comb begin
    rpm_off    = (latched_rpm_q == '0);
    rpm_idle   = !rpm_off && (latched_rpm_q < cfg_i.idle_rpm_limit);
    speed_busy = (latched_speed_q != '0) &&
                 ({1'b0, latched_speed_q} >= cfg_i.idle_speed_limit);
    rsum_add   = {1'b0, rpm_busy_sum_q} + (RsumW + 1)'(latched_rpm_q);
    ssum_add   = {1'b0, speed_busy_sum_q} + (SsumW + 1)'(latched_speed_q);
    rsum_next  = rsum_add[RsumW] ? '1 : rsum_add[RsumW-1:0];
    ssum_next  = ssum_add[SsumW] ? '1 : ssum_add[SsumW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= ST_RUN;
      latched_rpm_q      <= '0;
      latched_speed_q    <= '0;
      rpm_off_count_q    <= '0;
      rpm_idle_count_q   <= '0;
      rpm_busy_count_q   <= '0;
      rpm_busy_sum_q     <= '0;
      rpm_busy_min_q     <= '0;
      rpm_busy_max_q     <= '0;
      speed_busy_count_q <= '0;
      speed_busy_sum_q   <= '0;
      speed_busy_min_q   <= '0;
      speed_busy_max_q   <= '0;
      off_tenths_q       <= '0;
      idle_tenths_q      <= '0;
      busy_tenths_q      <= '0;
      off_secs_q         <= '0;
      idle_secs_q        <= '0;
      busy_secs_q        <= '0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        rpm_off_count_q    <= '0;
        rpm_idle_count_q   <= '0;
        rpm_busy_count_q   <= '0;
        rpm_busy_sum_q     <= '0;
        rpm_busy_min_q     <= '0;
        rpm_busy_max_q     <= '0;
        speed_busy_count_q <= '0;
        speed_busy_sum_q   <= '0;
        speed_busy_min_q   <= '0;
        speed_busy_max_q   <= '0;
        off_tenths_q       <= '0;
        idle_tenths_q      <= '0;
        busy_tenths_q      <= '0;
        off_secs_q         <= '0;
        idle_secs_q        <= '0;
        busy_secs_q        <= '0;
      end else if (accept) begin
        unique case (cmd_i.op)
          CMD_RPM: begin
            latched_rpm_q <= cmd_i.value;
          end
          CMD_SPEED: begin
            latched_speed_q <= cmd_i.value[SpeedW-1:0];
          end
          CMD_TICK: begin
            if (rpm_off) begin
              if (rpm_off_count_q != '1) begin
                rpm_off_count_q <= rpm_off_count_q + COUNT_BITS'(1);
                if (off_tenths_q == SecLast) begin
                  off_tenths_q <= '0;
                  off_secs_q   <= off_secs_q + COUNT_BITS'(1);
                end else begin
                  off_tenths_q <= off_tenths_q + 4'd1;
                end
              end
            end else if (rpm_idle) begin
              if (rpm_idle_count_q != '1) begin
                rpm_idle_count_q <= rpm_idle_count_q + COUNT_BITS'(1);
                if (idle_tenths_q == SecLast) begin
                  idle_tenths_q <= '0;
                  idle_secs_q   <= idle_secs_q + COUNT_BITS'(1);
                end else begin
                  idle_tenths_q <= idle_tenths_q + 4'd1;
                end
              end
            end else begin
              if (rpm_busy_count_q != '1) begin
                rpm_busy_count_q <= rpm_busy_count_q + COUNT_BITS'(1);
                if (busy_tenths_q == SecLast) begin
                  busy_tenths_q <= '0;
                  busy_secs_q   <= busy_secs_q + COUNT_BITS'(1);
                end else begin
                  busy_tenths_q <= busy_tenths_q + 4'd1;
                end
              end
              rpm_busy_sum_q <= rsum_next;
              if (rpm_busy_min_q == '0 || latched_rpm_q < rpm_busy_min_q) begin
                rpm_busy_min_q <= latched_rpm_q;
              end
              if (latched_rpm_q > rpm_busy_max_q) begin
                rpm_busy_max_q <= latched_rpm_q;
              end
            end
            if (speed_busy) begin
              if (speed_busy_count_q != '1) begin
                speed_busy_count_q <= speed_busy_count_q + COUNT_BITS'(1);
              end
              speed_busy_sum_q <= ssum_next;
              if (speed_busy_min_q == '0 || latched_speed_q < speed_busy_min_q) begin
                speed_busy_min_q <= latched_speed_q;
              end
              if (latched_speed_q > speed_busy_max_q) begin
                speed_busy_max_q <= latched_speed_q;
              end
            end
            latched_rpm_q   <= '0;
            latched_speed_q <= '0;
          end
          CMD_REPORT: begin
            // Statistics stay frozen while the dividers run.
          end
        endcase
      end
    end
  end

  eous_div #(.NUM_W(RsumW), .DEN_W(COUNT_BITS)) u_div_rpm (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(rpm_busy_sum_q),
    .den_i(rpm_busy_count_q), .busy_o(rmean_busy), .quo_o(rmean_quo)
  );

  eous_div #(.NUM_W(SsumW), .DEN_W(COUNT_BITS)) u_div_speed (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(speed_busy_sum_q),
    .den_i(speed_busy_count_q), .busy_o(smean_busy), .quo_o(smean_quo)
  );

  // Report assembly with saturation of seconds and means.
  always_comb begin
    off_ext  = {{SecW{1'b0}}, off_secs_q};
    idle_ext = {{SecW{1'b0}}, idle_secs_q};
    busy_ext = {{SecW{1'b0}}, busy_secs_q};
    out_d.off_seconds  = (off_ext > SecExtW'(SecMax)) ? SecMax : off_ext[SecW-1:0];
    out_d.idle_seconds = (idle_ext > SecExtW'(SecMax)) ? SecMax : idle_ext[SecW-1:0];
    out_d.busy_seconds = (busy_ext > SecExtW'(SecMax)) ? SecMax : busy_ext[SecW-1:0];
    out_d.rpm_min      = rpm_busy_min_q;
    out_d.rpm_max      = rpm_busy_max_q;
    out_d.speed_min    = speed_busy_min_q;
    out_d.speed_max    = speed_busy_max_q;
    if (rpm_busy_count_q == '0) begin
      out_d.rpm_mean = '0;
    end else if (rmean_quo > RsumW'(RpmMax)) begin
      out_d.rpm_mean = RpmMax;
    end else begin
      out_d.rpm_mean = rmean_quo[RpmW-1:0];
    end
    if (speed_busy_count_q == '0) begin
      out_d.speed_mean = '0;
    end else if (smean_quo > SsumW'(SpeedMax)) begin
      out_d.speed_mean = SpeedMax;
    end else begin
      out_d.speed_mean = smean_quo[SpeedW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (pop && out_valid_q) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q <= out_d;
    end
  end

  assign out_word_o = out_q;
  assign empty      = !out_valid_q;

endmodule

>>> rtl/engine_obd_usage_statistics.sv
// Top level of the engine usage statistics block from OBD-II mode-1 replies.
//
// The block watches received CAN frames for OBD-II mode-1 replies carrying
// engine speed or vehicle speed and latches the decoded values; a sample tick
// sorts the latched values as off, idle or busy and updates the counters and
// the busy sum, minimum and maximum; a report word returns the engine times in
// seconds together with busy minimum, mean and maximum for both channels and
// then clears the statistics. Frame and tick words pass the front end and the
// engine without waiting, so they can be pushed in every cycle while full is
// low. A report holds the engine while the serial dividers form the mean engine
// speed and the mean vehicle speed one bit per cycle; the words pushed behind
// it wait in the command queue. A report is only started once the previous
// report word has been popped.
module engine_obd_usage_statistics #(
  parameter int unsigned COUNT_BITS  = eous_pkg::CountBits,
  parameter int unsigned QUEUE_DEPTH = eous_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input words.
  input  eous_pkg::in_word_t  in_word_i,
  input  logic                push,
  output logic                full,
  // Report words.
  output eous_pkg::out_word_t out_word_o,
  output logic                empty,
  input  logic                pop,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import eous_pkg::*;

  cfg_t cfg_q;
  logic cfg_wr;
  logic reg_sel;

  cmd_t front_cmd, queue_cmd;
  logic front_valid, front_ready;
  logic queue_valid, queue_ready;

  // Registers sit at byte addresses 0 and 4, so address bit 2 picks one.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_rpm_limit   <= IdleRpmReset;
      cfg_q.idle_speed_limit <= IdleSpeedReset;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        RegIdleRpm:   cfg_q.idle_rpm_limit   <= pwdata[13:0];
        RegIdleSpeed: cfg_q.idle_speed_limit <= pwdata[8:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegIdleRpm:   prdata = 32'(cfg_q.idle_rpm_limit);
      RegIdleSpeed: prdata = 32'(cfg_q.idle_speed_limit);
    endcase
  end

  // The front end decodes frames and drops those that do not match.
  eous_front u_front (
    .clk_i,
    .rst_ni,
    .in_word_i,
    .push,
    .full,
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  // The queue lets ticks and frames keep arriving while a report runs.
  eous_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i,
    .rst_ni,
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_data_i  (front_cmd),
    .rd_valid_o (queue_valid),
    .rd_ready_i (queue_ready),
    .rd_data_o  (queue_cmd)
  );

  // The engine owns all statistics and the report register.
  eous_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_ready_o (queue_ready),
    .out_word_o,
    .empty,
    .pop
  );

endmodule

>>> sim/tb.sv
// Self-checking testbench of the engine usage statistics block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eous_pkg::*;

  // Cycles of quiet after the last report before the block counts as idle.
  localparam int unsigned SettleCycles = 4 * (CountBits + 16);
  // Cycles without any accepted or popped word or register access before the run is declared hung.
  localparam int unsigned QuietLimit   = 5000;
  localparam int unsigned PhaseWords   = 276;
  localparam int unsigned NumPhases    = 5;

  // Saturation points of the counters, both busy sums, the seconds and both means.
  localparam longint unsigned CountCap    = (64'd1 << CountBits) - 64'd1;
  localparam longint unsigned RpmSumCap   = (64'd1 << (CountBits + RpmW)) - 64'd1;
  localparam longint unsigned SpeedSumCap = (64'd1 << (CountBits + SpeedW)) - 64'd1;
  localparam longint unsigned SecondsCap  = (64'd1 << SecW) - 64'd1;
  localparam longint unsigned RpmCap      = (64'd1 << RpmW) - 64'd1;
  localparam longint unsigned SpeedCap    = (64'd1 << SpeedW) - 64'd1;

  // One row of the directed table. Where typed is set, the report that the
  // row causes is checked against want instead of the predicted value.
  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni  = 1'b0;
  in_word_t    in_word = '0;
  logic        push    = 1'b0;
  logic        full;
  out_word_t   out_word;
  logic        empty;
  logic        pop     = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted state of the block: configuration, latches and statistics.
  logic [13:0]     lim_rpm;
  logic [8:0]      lim_speed;
  logic [13:0]     rpm_latch;
  logic [7:0]      speed_latch;
  longint unsigned eng_off_cnt, eng_idle_cnt, eng_busy_cnt, eng_busy_sum;
  logic [13:0]     eng_busy_min, eng_busy_max;
  longint unsigned veh_busy_cnt, veh_busy_sum;
  logic [7:0]      veh_busy_min, veh_busy_max;

  // Reports still owed by the block, oldest first.
  out_word_t   report_q[$];
  int unsigned errors = 0;
  // Set during the phase in which neither side ever idles.
  bit          calm   = 1'b0;
  int unsigned quiet  = 0;

  engine_obd_usage_statistics uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word),
    .push       (push),
    .full       (full),
    .out_word_o (out_word),
    .empty      (empty),
    .pop        (pop),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint unsigned sat_inc(longint unsigned c);
    return (c < CountCap) ? c + 64'd1 : CountCap;
  endfunction

  function automatic longint unsigned sat_add(longint unsigned s, longint unsigned v,
                                              longint unsigned cap);
    return (cap - s < v) ? cap : s + v;
  endfunction

  function automatic longint unsigned mean_of(longint unsigned sum, longint unsigned cnt,
                                              longint unsigned cap);
    longint unsigned m;
    if (cnt == 0) return 0;
    m = sum / cnt;
    return (m > cap) ? cap : m;
  endfunction

  function automatic longint unsigned to_seconds(longint unsigned cnt);
    longint unsigned s;
    s = cnt / 64'd10;
    return (s > SecondsCap) ? SecondsCap : s;
  endfunction

  function automatic in_word_t mk_word(logic [1:0] m, logic ext, logic [28:0] id,
                                       logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                       logic [7:0] b3, logic [7:0] b4);
    in_word_t w;
    w.mode        = mode_e'(m);
    w.is_extended = ext;
    w.frame_id    = id;
    w.data_byte0  = b0;
    w.data_byte1  = b1;
    w.data_byte2  = b2;
    w.data_byte3  = b3;
    w.data_byte4  = b4;
    return w;
  endfunction

  // Engine speed reply carrying the raw 16-bit value (quarter rpm).
  function automatic in_word_t rpm_frame(logic [15:0] raw);
    return mk_word(MODE_FRAME, 1'b0, ReplyId, LenRpm, SvcReply, PidRpm, raw[15:8], raw[7:0]);
  endfunction

  function automatic in_word_t speed_frame(logic [7:0] kmh);
    return mk_word(MODE_FRAME, 1'b0, ReplyId, LenSpeed, SvcReply, PidSpeed, kmh, 8'h00);
  endfunction

  function automatic in_word_t tick_word();
    return mk_word(MODE_TICK, 1'($urandom_range(1)), 29'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic in_word_t report_word();
    return mk_word(MODE_REPORT, 1'($urandom_range(1)), 29'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // Random stimulus: mostly well-formed replies and ticks, so that all three
  // sorting bins fill up, plus report words, broken replies and plain noise.
  function automatic in_word_t random_word();
    int unsigned sel;
    in_word_t    w;
    sel = $urandom_range(99);
    if (sel < 35) begin
      w = rpm_frame($urandom_range(1) ? 16'($urandom_range(8000)) : 16'($urandom));
    end else if (sel < 55) begin
      w = speed_frame($urandom_range(1) ? 8'($urandom_range(20)) : 8'($urandom));
    end else if (sel < 83) begin
      w = tick_word();
    end else if (sel < 88) begin
      w = report_word();
    end else if (sel < 95) begin
      // A reply altered in exactly one place.
      w = $urandom_range(1) ? rpm_frame(16'($urandom)) : speed_frame(8'($urandom));
      case ($urandom_range(4))
        0: w.is_extended = 1'b1;
        1: w.frame_id    = w.frame_id ^ (29'd1 << $urandom_range(28));
        2: w.data_byte1  = 8'($urandom);
        3: w.data_byte0  = w.data_byte0 ^ (8'd1 << $urandom_range(7));
        default: w.data_byte2 = w.data_byte2 ^ (8'd1 << $urandom_range(7));
      endcase
    end else begin
      w = mk_word(2'($urandom_range(3)), 1'($urandom_range(1)), 29'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
    return w;
  endfunction

  // Applies one accepted word to the predicted state; a report word also
  // yields the word the block must return.
  task automatic track_usage(input in_word_t w, output bit has_rep, output out_word_t rep);
    logic [13:0] r;
    logic [7:0]  s;
    has_rep = 1'b0;
    rep     = '0;
    case (w.mode)
      MODE_FRAME: begin
        if (!w.is_extended && w.frame_id == ReplyId && w.data_byte1 == SvcReply) begin
          if (w.data_byte0 == LenRpm && w.data_byte2 == PidRpm) begin
            rpm_latch = 14'({w.data_byte3, w.data_byte4} >> 2);
          end else if (w.data_byte0 == LenSpeed && w.data_byte2 == PidSpeed) begin
            speed_latch = w.data_byte3;
          end
        end
      end
      MODE_TICK: begin
        r = rpm_latch;
        s = speed_latch;
        if (r == 0) begin
          eng_off_cnt = sat_inc(eng_off_cnt);
        end else if (r < lim_rpm) begin
          eng_idle_cnt = sat_inc(eng_idle_cnt);
        end else begin
          eng_busy_cnt = sat_inc(eng_busy_cnt);
          eng_busy_sum = sat_add(eng_busy_sum, 64'(r), RpmSumCap);
          // A minimum of zero means no busy sample has been seen yet.
          if (eng_busy_min == 0 || r < eng_busy_min) eng_busy_min = r;
          if (r > eng_busy_max) eng_busy_max = r;
        end
        // Off and idle vehicle speed samples are not counted at all.
        if (s != 0 && {1'b0, s} >= lim_speed) begin
          veh_busy_cnt = sat_inc(veh_busy_cnt);
          veh_busy_sum = sat_add(veh_busy_sum, 64'(s), SpeedSumCap);
          if (veh_busy_min == 0 || s < veh_busy_min) veh_busy_min = s;
          if (s > veh_busy_max) veh_busy_max = s;
        end
        rpm_latch   = '0;
        speed_latch = '0;
      end
      MODE_REPORT: begin
        has_rep          = 1'b1;
        rep.off_seconds  = 29'(to_seconds(eng_off_cnt));
        rep.idle_seconds = 29'(to_seconds(eng_idle_cnt));
        rep.busy_seconds = 29'(to_seconds(eng_busy_cnt));
        rep.rpm_min      = eng_busy_min;
        rep.rpm_mean     = 14'(mean_of(eng_busy_sum, eng_busy_cnt, RpmCap));
        rep.rpm_max      = eng_busy_max;
        rep.speed_min    = veh_busy_min;
        rep.speed_mean   = 8'(mean_of(veh_busy_sum, veh_busy_cnt, SpeedCap));
        rep.speed_max    = veh_busy_max;
        // A report clears the statistics but leaves the latches alone.
        eng_off_cnt  = 0;
        eng_idle_cnt = 0;
        eng_busy_cnt = 0;
        eng_busy_sum = 0;
        eng_busy_min = '0;
        eng_busy_max = '0;
        veh_busy_cnt = 0;
        veh_busy_sum = 0;
        veh_busy_min = '0;
        veh_busy_max = '0;
      end
      default: ;  // The unused mode changes nothing.
    endcase
  endtask

  // Offers one word and returns at the edge that takes it. push stays high on
  // return, so back-to-back words see it drop only where the sender idles at random outside the calm phase.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    bit        has_rep;
    out_word_t rep;
    while (!calm && $urandom_range(99) < 10) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_word <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    track_usage(w, has_rep, rep);
    if (has_rep) report_q.push_back(typed ? want : rep);
  endtask

  // Stops the sender until every owed report has come back and the engine
  // has had time to finish any frames and ticks still queued.
  task automatic drain_reports();
    push <= 1'b0;
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegIdleRpm) lim_rpm = val[13:0];
    else lim_speed = val[8:0];
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, actual %0d", $realtime, name, want, got);
    end
  endtask

  // Result side: pop at random, and check every word taken against the
  // oldest owed report.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && pop && !empty) begin
      if (report_q.size() == 0) begin
        errors++;
        $display("%0t: no report expected, actual %p", $realtime, out_word);
      end else begin
        want = report_q.pop_front();
        check_field("off_seconds", 64'(want.off_seconds), 64'(out_word.off_seconds));
        check_field("idle_seconds", 64'(want.idle_seconds), 64'(out_word.idle_seconds));
        check_field("busy_seconds", 64'(want.busy_seconds), 64'(out_word.busy_seconds));
        check_field("rpm_min", 64'(want.rpm_min), 64'(out_word.rpm_min));
        check_field("rpm_mean", 64'(want.rpm_mean), 64'(out_word.rpm_mean));
        check_field("rpm_max", 64'(want.rpm_max), 64'(out_word.rpm_max));
        check_field("speed_min", 64'(want.speed_min), 64'(out_word.speed_min));
        check_field("speed_mean", 64'(want.speed_mean), 64'(out_word.speed_mean));
        check_field("speed_max", 64'(want.speed_max), 64'(out_word.speed_max));
      end
    end
    pop <= calm || ($urandom_range(99) >= 10);
  end

  // Watchdog: any accepted word or register access counts as progress.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("%0t: no progress for %0d cycles", $realtime, QuietLimit);
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    dir_row_t    rows[$];
    dir_row_t    row;
    out_word_t   peak;
    logic [13:0] rpm_cfg;
    logic [8:0]  speed_cfg;

    lim_rpm      = IdleRpmReset;
    lim_speed    = IdleSpeedReset;
    rpm_latch    = '0;
    speed_latch  = '0;
    eng_off_cnt  = 0;
    eng_idle_cnt = 0;
    eng_busy_cnt = 0;
    eng_busy_sum = 0;
    eng_busy_min = '0;
    eng_busy_max = '0;
    veh_busy_cnt = 0;
    veh_busy_sum = 0;
    veh_busy_min = '0;
    veh_busy_max = '0;

    // A single busy sample at the top of both ranges: min, mean and max all
    // equal that sample, and one sample is still zero seconds.
    peak = '0;
    peak.rpm_min    = 14'h3FFF;
    peak.rpm_mean   = 14'h3FFF;
    peak.rpm_max    = 14'h3FFF;
    peak.speed_min  = 8'hFF;
    peak.speed_mean = 8'hFF;
    peak.speed_max  = 8'hFF;

    // Directed table. Rows without a typed report go to the predictor.
    rows.push_back('{report_word(), 1'b1, '0});          // report right after reset
    rows.push_back('{rpm_frame(16'hFFFF), 1'b0, '0});    // highest engine speed
    rows.push_back('{speed_frame(8'hFF), 1'b0, '0});     // highest vehicle speed
    rows.push_back('{tick_word(), 1'b0, '0});
    rows.push_back('{report_word(), 1'b1, peak});
    // Replies that must be ignored: extended id, wrong id, wrong service,
    // length that does not fit the parameter.
    row = '{rpm_frame(16'h1000), 1'b0, '0};
    row.w.is_extended = 1'b1;
    rows.push_back(row);
    row = '{rpm_frame(16'h1000), 1'b0, '0};
    row.w.frame_id = ReplyId + 29'd1;
    rows.push_back(row);
    row = '{speed_frame(8'd50), 1'b0, '0};
    row.w.data_byte1 = SvcReply - 8'd1;
    rows.push_back(row);
    row = '{rpm_frame(16'h2000), 1'b0, '0};
    row.w.data_byte0 = LenSpeed;
    rows.push_back(row);
    row = '{speed_frame(8'd60), 1'b0, '0};
    row.w.data_byte0 = LenRpm;
    rows.push_back(row);
    rows.push_back('{tick_word(), 1'b0, '0});            // nothing latched: engine off
    rows.push_back('{rpm_frame(16'h0004), 1'b0, '0});    // 1 rpm, idle
    rows.push_back('{speed_frame(8'd9), 1'b0, '0});      // just below the speed limit
    rows.push_back('{tick_word(), 1'b0, '0});
    rows.push_back('{rpm_frame(16'h1900), 1'b0, '0});    // exactly at the rpm limit
    rows.push_back('{speed_frame(8'd10), 1'b0, '0});     // exactly at the speed limit
    rows.push_back('{tick_word(), 1'b0, '0});
    rows.push_back('{rpm_frame(16'h18FC), 1'b0, '0});    // one below the rpm limit
    rows.push_back('{speed_frame(8'd0), 1'b0, '0});      // standing still
    rows.push_back('{tick_word(), 1'b0, '0});
    rows.push_back('{mk_word(2'd3, 1'b0, ReplyId, LenRpm, SvcReply, PidRpm, 8'h40, 8'h00),
                     1'b0, '0});                         // unused mode
    rows.push_back('{tick_word(), 1'b0, '0});
    rows.push_back('{report_word(), 1'b0, '0});
    rows.push_back('{report_word(), 1'b0, '0});          // right after a clear

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(RegIdleRpm, 32'(IdleRpmReset));
    write_reg(RegIdleSpeed, 32'(IdleSpeedReset));
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);
    drain_reports();

    // Random phases, each under its own pair of limits. The second phase runs
    // without idling on either side, the third stops once mid-way to let the
    // block run dry.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin rpm_cfg = 14'd0;     speed_cfg = 9'd0;   end
        1: begin rpm_cfg = 14'd10000; speed_cfg = 9'd300; end
        3: begin rpm_cfg = 14'd1600;  speed_cfg = 9'd255; end
        default: begin
          rpm_cfg   = 14'($urandom_range(10000));
          speed_cfg = 9'($urandom_range(300));
        end
      endcase
      write_reg(RegIdleRpm, 32'(rpm_cfg));
      write_reg(RegIdleSpeed, 32'(speed_cfg));
      calm = (p == 1);
      for (int n = 0; n < PhaseWords; n++) begin
        if (p == 2 && n == PhaseWords / 2) drain_reports();
        send_word(random_word(), 1'b0, '0);
      end
      drain_reports();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
